/* hw/rtl/ldf_pkg.sv */
// Shared types and constants for the length-prefixed deframer.
// No dependencies.
package ldf_pkg;

	localparam int LDF_LEN_BYTES = 4;
	localparam int LDF_ID_BYTES  = 4;
	localparam int LDF_Q_DEPTH   = 4;
	localparam int LDF_REG_BYTES = 4;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [31:0] frame_id;
		logic [31:0] frame_len;
		logic        first_of_frame;
		logic        last_of_frame;
		logic        empty_frame;
	} ldf_word_t;

endpackage

/* hw/rtl/ldf_front.sv */
// Front end: collects the header, tracks the payload count and builds result words.
// Depends on ldf_pkg.
module ldf_front import ldf_pkg::*; #(
	parameter int LEN_FIELD_BYTES = LDF_LEN_BYTES,
	parameter int ID_FIELD_BYTES  = LDF_ID_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	output logic       res_valid,
	output ldf_word_t  res_word
);

	localparam int HDR_BYTES = LEN_FIELD_BYTES + ID_FIELD_BYTES;
	localparam int HIDX_W    = $clog2(HDR_BYTES);
	localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(HDR_BYTES - 1);

	logic              in_payload_q;
	logic [HIDX_W-1:0] hidx_q;
	logic [31:0]       len_q;
	logic [31:0]       id_q;
	logic [31:0]       left_q;

	logic [31:0] len_hdr;
	logic [31:0] id_hdr;
	logic        hdr_done;
	logic [31:0] left_dec;

	always_comb begin
		len_hdr = (hidx_q == '0) ? 32'd0 : len_q;
		id_hdr  = (hidx_q == '0) ? 32'd0 : id_q;
		for (int k = 0; k < LDF_REG_BYTES; k++) begin
			if (k < LEN_FIELD_BYTES && hidx_q == HIDX_W'(k))
				len_hdr[8*k +: 8] = in_byte;
			if (k < ID_FIELD_BYTES && hidx_q == HIDX_W'(LEN_FIELD_BYTES + k))
				id_hdr[8*k +: 8] = in_byte;
		end
	end

	assign hdr_done = (hidx_q == HIDX_LAST);
	assign left_dec = left_q - 32'd1;

	always_comb begin
		res_word = '0;
		if (in_payload_q) begin
			res_valid               = 1'b1;
			res_word.payload_byte   = in_byte;
			res_word.frame_id       = id_q;
			res_word.frame_len      = len_q;
			res_word.first_of_frame = (left_q == len_q);
			res_word.last_of_frame  = (left_q == 32'd1);
		end else begin
			res_valid               = hdr_done && (len_hdr == 32'd0);
			res_word.frame_id       = id_hdr;
			res_word.frame_len      = len_hdr;
			res_word.first_of_frame = 1'b1;
			res_word.last_of_frame  = 1'b1;
			res_word.empty_frame    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hidx_q       <= '0;
			len_q        <= '0;
			id_q         <= '0;
			left_q       <= '0;
		end else if (step) begin
			if (in_payload_q) begin
				left_q <= left_dec;
				if (left_dec == 32'd0)
					in_payload_q <= 1'b0;
			end else begin
				len_q <= len_hdr;
				id_q  <= id_hdr;
				if (hdr_done) begin
					hidx_q <= '0;
					if (len_hdr != 32'd0) begin
						in_payload_q <= 1'b1;
						left_q       <= len_hdr;
					end
				end else begin
					hidx_q <= hidx_q + HIDX_W'(1);
				end
			end
		end
	end

	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> left_q != 32'd0)
		else $error("payload state with zero bytes left");

	a_hidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		hidx_q <= HIDX_LAST)
		else $error("header index out of range");

	a_hidx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> hidx_q == '0)
		else $error("header index not cleared during payload");

	a_enter_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !in_payload_q && hdr_done && len_hdr != 32'd0) |=> in_payload_q)
		else $error("nonempty header did not enter payload");

endmodule

/* hw/rtl/ldf_queue.sv */
// Back end: short word queue holding results until the receiver pops them.
// Depends on ldf_pkg.
module ldf_queue import ldf_pkg::*; #(
	parameter int DEPTH = LDF_Q_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  ldf_word_t wr_word,
	input  logic      rd_en,
	output ldf_word_t rd_word,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	ldf_word_t         mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("queue count overflow");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("result word dropped on full queue");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CNT_W'(1) && do_rd && !do_wr) |=> empty)
		else $error("queue not empty after last pop");

endmodule

/* hw/rtl/length_prefixed_deframer.sv */
// Top level of the length-prefixed deframer: front parser feeding a result queue.
// Depends on ldf_pkg, ldf_front, ldf_queue.
//
// Input channel: one stream byte per word on in_byte, taken when push is high
// and full is low. Each frame is a little-endian length field, then a
// little-endian message ID field, then the payload bytes.
// Result channel: while empty is low the oldest result word is on the output
// ports; it is taken when pop is high. Every payload byte gives one word
// tagged with frame_id, frame_len, first_of_frame and last_of_frame. A frame
// of length zero gives one word with empty_frame set and payload_byte zero
// when its last header byte arrives. Header bytes give no word.
// Throughput: one input byte per cycle, sustained while results are popped.
// A result word is registered into the queue when its byte is taken.
// The result queue holds LDF_Q_DEPTH words; when the receiver stalls it
// fills and full rises, holding off input until a word is popped.
// Reset clears the header collector, the payload counter and the queue; the
// next byte after reset starts a new header.
module length_prefixed_deframer import ldf_pkg::*; #(
	parameter int LEN_FIELD_BYTES = LDF_LEN_BYTES,
	parameter int ID_FIELD_BYTES  = LDF_ID_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  payload_byte,
	output logic [31:0] frame_id,
	output logic [31:0] frame_len,
	output logic        first_of_frame,
	output logic        last_of_frame,
	output logic        empty_frame
);

	logic      step;
	logic      res_valid;
	ldf_word_t res_word;
	ldf_word_t out_word;

	assign step = push && !full;

	ldf_front #(
		.LEN_FIELD_BYTES(LEN_FIELD_BYTES),
		.ID_FIELD_BYTES (ID_FIELD_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.in_byte  (in_byte),
		.res_valid(res_valid),
		.res_word (res_word)
	);

	ldf_queue #(
		.DEPTH(LDF_Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (step && res_valid),
		.wr_word(res_word),
		.rd_en  (pop),
		.rd_word(out_word),
		.full   (full),
		.empty  (empty)
	);

	assign payload_byte   = out_word.payload_byte;
	assign frame_id       = out_word.frame_id;
	assign frame_len      = out_word.frame_len;
	assign first_of_frame = out_word.first_of_frame;
	assign last_of_frame  = out_word.last_of_frame;
	assign empty_frame    = out_word.empty_frame;

endmodule

/* dv/length_prefixed_deframer_tb.sv */
// Self-checking testbench for length_prefixed_deframer: drives framed byte streams
// through the push/full side and checks every popped word against an in-bench predictor.
// Depends on ldf_pkg and the length_prefixed_deframer RTL.
module length_prefixed_deframer_tb;
	import ldf_pkg::*;

	localparam int HDR_BYTES = LDF_LEN_BYTES + LDF_ID_BYTES;
	localparam int QUIET_LIMIT = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  in_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  payload_byte;
	logic [31:0] frame_id;
	logic [31:0] frame_len;
	logic        first_of_frame;
	logic        last_of_frame;
	logic        empty_frame;

	length_prefixed_deframer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.empty(empty),
		.pop(pop),
		.payload_byte(payload_byte),
		.frame_id(frame_id),
		.frame_len(frame_len),
		.first_of_frame(first_of_frame),
		.last_of_frame(last_of_frame),
		.empty_frame(empty_frame)
	);

	always #5 clk = ~clk;

	// deframer state as predicted
	bit          in_body;
	int          hdr_pos;
	logic [31:0] hdr_len;
	logic [31:0] hdr_id;
	logic [31:0] body_left;

	ldf_word_t pending_words[$];
	int        bad_words;
	int        bytes_sent;
	int        pop_stall;
	int        quiet_cycles;
	bit        idle_on = 1'b1;

	function automatic void deframe_byte(input logic [7:0] b);
		ldf_word_t w;
		if (in_body) begin
			w.payload_byte   = b;
			w.frame_id       = hdr_id;
			w.frame_len      = hdr_len;
			w.first_of_frame = (body_left == hdr_len);
			w.last_of_frame  = (body_left == 32'd1);
			w.empty_frame    = 1'b0;
			pending_words = {pending_words, w};
			body_left = body_left - 32'd1;
			if (body_left == 32'd0) begin
				in_body = 1'b0;
				hdr_pos = 0;
			end
			return;
		end
		if (hdr_pos == 0) begin
			hdr_len = '0;
			hdr_id  = '0;
		end
		if (hdr_pos < LDF_LEN_BYTES) begin
			if (hdr_pos < LDF_REG_BYTES)
				hdr_len[hdr_pos*8 +: 8] = b;
		end else if (hdr_pos - LDF_LEN_BYTES < LDF_REG_BYTES) begin
			hdr_id[(hdr_pos - LDF_LEN_BYTES)*8 +: 8] = b;
		end
		if (hdr_pos + 1 >= HDR_BYTES) begin
			hdr_pos = 0;
			if (hdr_len == 32'd0) begin
				w.payload_byte   = 8'h00;
				w.frame_id       = hdr_id;
				w.frame_len      = hdr_len;
				w.first_of_frame = 1'b1;
				w.last_of_frame  = 1'b1;
				w.empty_frame    = 1'b1;
				pending_words = {pending_words, w};
			end else begin
				in_body   = 1'b1;
				body_left = hdr_len;
			end
		end else begin
			hdr_pos = hdr_pos + 1;
		end
	endfunction

	// push stays high between words unless a gap is taken
	task automatic send_byte(input logic [7:0] b);
		push <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (full);
		deframe_byte(b);
		bytes_sent++;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send_header(input logic [31:0] len, input logic [31:0] id);
		for (int i = 0; i < LDF_LEN_BYTES; i++)
			send_byte(i < 4 ? len[i*8 +: 8] : 8'($urandom));
		for (int i = 0; i < LDF_ID_BYTES; i++)
			send_byte(i < 4 ? id[i*8 +: 8] : 8'($urandom));
	endtask

	task automatic send_frame(input logic [31:0] len);
		send_header(len, $urandom);
		for (int i = 0; i < len; i++)
			send_byte($urandom);
	endtask

	function automatic logic [31:0] pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 3)
			return 32'd0;
		if (r == 19)
			return $urandom_range(13, 64);
		return $urandom_range(1, 12);
	endfunction

	task automatic test_edge_frames();
		send_header(32'd0, 32'd0);
		send_header(32'd1, 32'hFFFF_FFFF);
		send_byte(8'hFF);
		send_header(32'd2, 32'h8000_0001);
		send_byte(8'h00);
		send_byte(8'h7F);
	endtask

	task automatic test_random_frames(input int target);
		int stop_at;
		stop_at = bytes_sent + target;
		while (bytes_sent < stop_at)
			send_frame(pick_length());
	endtask

	task automatic test_two_byte_length();
		send_frame($urandom_range(256, 300));
	endtask

	task automatic test_back_to_back(input int target);
		idle_on = 1'b0;
		test_random_frames(target);
	endtask

	// header bytes high in the length field; the frame stays open at the end
	task automatic test_unbounded_frame();
		send_header(32'hFFFF_FFFF, $urandom);
		repeat (24)
			send_byte($urandom);
	endtask

	// result side: random pop stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_stall != 0) begin
			pop <= 1'b0;
			pop_stall <= pop_stall - 1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			pop <= 1'b0;
			pop_stall <= $urandom_range(0, 10);
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_words
		ldf_word_t got;
		ldf_word_t want;
		if (arst_n && pop && !empty) begin
			got = {payload_byte, frame_id, frame_len, first_of_frame, last_of_frame,
				empty_frame};
			if (pending_words.size() == 0) begin
				if (bad_words < 10)
					$display("unexpected word: byte=%h id=%h len=%h first=%b last=%b empty=%b",
						got.payload_byte, got.frame_id, got.frame_len,
						got.first_of_frame, got.last_of_frame, got.empty_frame);
				bad_words++;
			end else begin
				want = pending_words.pop_front();
				if (got !== want) begin
					if (bad_words < 10) begin
						$display("mismatch exp: byte=%h id=%h len=%h first=%b last=%b empty=%b",
							want.payload_byte, want.frame_id, want.frame_len,
							want.first_of_frame, want.last_of_frame, want.empty_frame);
						$display("         got: byte=%h id=%h len=%h first=%b last=%b empty=%b",
							got.payload_byte, got.frame_id, got.frame_len,
							got.first_of_frame, got.last_of_frame, got.empty_frame);
					end
					bad_words++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_frames();
		test_random_frames(280);
		test_two_byte_length();
		test_back_to_back(110);
		test_unbounded_frame();
		push <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (bad_words == 0 && pending_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
